// File: rtl/core/ctes_pkg.sv
// Shared types, constants and calendar tables for the calendar to epoch seconds pipeline.
// No dependencies; imported by every module under rtl/core.
package ctes_pkg;

    localparam int YEAR_W   = 12;           // year field width
    localparam int QDIV_W   = YEAR_W - 2;   // width of year / 4
    localparam int Q25_W    = 6;            // width of (year / 4) / 25
    localparam int DAYS_W   = 20;
    localparam int TOD_W    = 17;
    localparam int SECS_W   = 36;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    // floor(m / 25) == (m * 41) >> 10 holds exactly for every m below 1024
    localparam logic [15:0]       Q25_MUL   = 16'd41;
    localparam int                Q25_SHIFT = 10;
    localparam logic [YEAR_W-1:0] EPOCH_YEAR  = 12'd1970;
    localparam logic [QDIV_W-1:0] LEAPS_1969  = 10'd477;  // leap years in 1..1969
    localparam logic [3:0]        MONTH_JAN   = 4'd0;
    localparam logic [3:0]        MONTH_FEB   = 4'd1;
    localparam logic [3:0]        MONTH_LAST  = 4'd11;
    localparam logic [4:0]        HOUR_LAST   = 5'd23;
    localparam logic [5:0]        MINSEC_LAST = 6'd59;
    localparam logic [DAYS_W-1:0] DAYS_PER_YEAR = 20'd365;
    localparam logic [16:0]       SECS_PER_DAY  = 17'd86400;
    localparam logic [TOD_W-1:0]  SECS_PER_HOUR = 17'd3600;
    localparam logic [TOD_W-1:0]  SECS_PER_MIN  = 17'd60;

    // stage 0 -> stage 1
    typedef struct packed {
        logic [3:0]        month;
        logic [4:0]        day;
        logic [YEAR_W-1:0] year;
        logic [4:0]        hour;
        logic [5:0]        minute;
        logic [5:0]        second;
        logic              fields_ok;   // month and time of day in range
        logic [Q25_W-1:0]  q_year;      // floor(year / 100)
        logic [Q25_W-1:0]  q_prev;      // floor((year - 1) / 100)
    } prep_t;

    // stage 1 -> stage 2
    typedef struct packed {
        logic              ok;
        logic              after_epoch;
        logic [YEAR_W-1:0] year_off;    // year - 1970
        logic [QDIV_W-1:0] leap_corr;   // leap years in 1970..year-1
        logic [8:0]        day_of_year;
        logic [TOD_W-1:0]  tod;
    } year_t;

    // stage 2 -> stage 3
    typedef struct packed {
        logic              ok;
        logic [DAYS_W-1:0] days;
        logic [TOD_W-1:0]  tod;
    } days_t;

    typedef struct packed {
        logic              ok;
        logic [SECS_W-1:0] secs;
    } result_t;

    // load enables, one per register stage
    typedef struct packed {
        logic s0;
        logic s1;
        logic s2;
        logic s3;
    } pipe_en_t;

    function automatic logic [4:0] month_len(input logic [3:0] month);
        logic [4:0] len;
        unique case (month)
            4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
            4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
            MONTH_FEB:                                 len = 5'd28;
            default:                                   len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before_month(input logic [3:0] month);
        logic [8:0] d;
        unique case (month)
            MONTH_JAN: d = 9'd0;
            MONTH_FEB: d = 9'd31;
            4'd2:      d = 9'd59;
            4'd3:      d = 9'd90;
            4'd4:      d = 9'd120;
            4'd5:      d = 9'd151;
            4'd6:      d = 9'd181;
            4'd7:      d = 9'd212;
            4'd8:      d = 9'd243;
            4'd9:      d = 9'd273;
            4'd10:     d = 9'd304;
            4'd11:     d = 9'd334;
            default:   d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// File: rtl/core/calendar_to_epoch_seconds.sv
// Calendar time (GMT) to seconds since 1970-01-01, four register stages.
// An accepted input moves through stages 0 to 3 before its result appears on m_tdata/m_tuser.
// Throughput: one item per cycle; each stage holds while the one after it is full
// and stalled, and an empty stage accepts even while the output waits.
// Reset: aresetn (synchronous, active low) clears the stage valid bits only.
// Depends on ctes_pkg, ctes_year_prep, ctes_day_count, ctes_sec_scale.
module calendar_to_epoch_seconds import ctes_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // month_index[3:0], day_index[8:4], year_value[20:9], hour_value[25:21],
    // minute_value[31:26], second_value[37:32], zero [39:38]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // unix_secs[35:0], zero [39:36]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // valid_res[0]
    output logic                   m_tuser
);

    logic [3:0] valid_reg;
    logic [3:0] valid_next;
    pipe_en_t   en;
    prep_t      prep;
    days_t      days;
    result_t    result;

    // a stage loads when it is empty or its contents move on
    always_comb begin
        en.s3 = !valid_reg[3] || m_tready;
        en.s2 = !valid_reg[2] || en.s3;
        en.s1 = !valid_reg[1] || en.s2;
        en.s0 = !valid_reg[0] || en.s1;
    end

    always_comb begin
        valid_next = valid_reg;
        if (en.s0) begin
            valid_next[0] = s_tvalid;
        end
        if (en.s1) begin
            valid_next[1] = valid_reg[0];
        end
        if (en.s2) begin
            valid_next[2] = valid_reg[1];
        end
        if (en.s3) begin
            valid_next[3] = valid_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    ctes_year_prep u_prep (
        .aclk   (aclk),
        .load   (en.s0),
        .month  (s_tdata[3:0]),
        .day    (s_tdata[8:4]),
        .year   (s_tdata[20:9]),
        .hour   (s_tdata[25:21]),
        .minute (s_tdata[31:26]),
        .second (s_tdata[37:32]),
        .prep   (prep)
    );

    ctes_day_count u_days (
        .aclk      (aclk),
        .load_year (en.s1),
        .load_days (en.s2),
        .prep      (prep),
        .days      (days)
    );

    ctes_sec_scale u_secs (
        .aclk   (aclk),
        .load   (en.s3),
        .days   (days),
        .result (result)
    );

    assign s_tready = en.s0;
    assign m_tvalid = valid_reg[3];
    assign m_tdata  = OUT_TDATA_W'(result.secs);
    assign m_tuser  = result.ok;

    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("rejected item carries nonzero seconds");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg == 4'hF) && !m_tready |-> !s_tready)
        else $error("input taken while pipeline full and stalled");

    a_accept_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> valid_reg[0])
        else $error("accepted item did not enter stage 0");

    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(result.secs) && $stable(result.ok))
        else $error("stalled result changed");

endmodule

// File: rtl/core/ctes_year_prep.sv
// Stage 0: range checks on month and time of day, and the divide-by-100 of the year
// and of the year before it by reciprocal multiply. Depends on ctes_pkg.
module ctes_year_prep import ctes_pkg::*; (
    input  logic              aclk,
    input  logic              load,
    input  logic [3:0]        month,
    input  logic [4:0]        day,
    input  logic [YEAR_W-1:0] year,
    input  logic [4:0]        hour,
    input  logic [5:0]        minute,
    input  logic [5:0]        second,
    output prep_t             prep
);

    prep_t             prep_reg;
    prep_t             prep_next;
    logic [YEAR_W-1:0] year_prev;
    logic [15:0]       prod_year;
    logic [15:0]       prod_prev;

    // year 0 wraps here; those years never reach the whole-year sum
    assign year_prev = year - YEAR_W'(1);
    assign prod_year = 16'(year[YEAR_W-1:2]) * Q25_MUL;
    assign prod_prev = 16'(year_prev[YEAR_W-1:2]) * Q25_MUL;

    always_comb begin
        prep_next.month     = month;
        prep_next.day       = day;
        prep_next.year      = year;
        prep_next.hour      = hour;
        prep_next.minute    = minute;
        prep_next.second    = second;
        prep_next.fields_ok = (month <= MONTH_LAST) && (hour <= HOUR_LAST)
                           && (minute <= MINSEC_LAST) && (second <= MINSEC_LAST);
        prep_next.q_year    = prod_year[Q25_SHIFT +: Q25_W];
        prep_next.q_prev    = prod_prev[Q25_SHIFT +: Q25_W];
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            prep_reg <= prep_next;
        end
    end

    assign prep = prep_reg;

endmodule

// File: rtl/core/ctes_day_count.sv
// Stages 1 and 2: leap rule, day-of-month check, day of year, time of day,
// then the closed-form whole-year day count. Depends on ctes_pkg.
module ctes_day_count import ctes_pkg::*; (
    input  logic  aclk,
    input  logic  load_year,
    input  logic  load_days,
    input  prep_t prep,
    output days_t days
);

    year_t             year_reg;
    year_t             year_next;
    days_t             days_reg;
    days_t             days_next;
    logic              leap;
    logic [10:0]       hundreds;
    logic [YEAR_W-1:0] year_prev;
    logic [QDIV_W-1:0] quarter_prev;
    logic [QDIV_W-1:0] leaps_prev;
    logic [5:0]        month_limit;
    logic [DAYS_W-1:0] whole_years;

    // leap: divisible by 4, and either not by 100 or by 400
    assign hundreds = 11'(prep.q_year) * 11'd25;
    assign leap = (prep.year[1:0] == 2'b00)
               && ((hundreds != 11'(prep.year[YEAR_W-1:2])) || (prep.q_year[1:0] == 2'b00));

    assign year_prev    = prep.year - YEAR_W'(1);
    assign quarter_prev = year_prev[YEAR_W-1:2];
    assign leaps_prev   = quarter_prev - QDIV_W'(prep.q_prev) + QDIV_W'(prep.q_prev[Q25_W-1:2]);
    assign month_limit  = 6'(month_len(prep.month))
                        + 6'((prep.month == MONTH_FEB) && leap);

    always_comb begin
        year_next.ok          = prep.fields_ok && (6'(prep.day) < month_limit);
        year_next.after_epoch = prep.year > EPOCH_YEAR;
        year_next.year_off    = prep.year - EPOCH_YEAR;
        year_next.leap_corr   = leaps_prev - LEAPS_1969;
        year_next.day_of_year = days_before_month(prep.month)
                              + 9'((prep.month > MONTH_FEB) && leap)
                              + 9'(prep.day);
        year_next.tod         = TOD_W'(prep.hour) * SECS_PER_HOUR
                              + TOD_W'(prep.minute) * SECS_PER_MIN
                              + TOD_W'(prep.second);
    end

    always_ff @(posedge aclk) begin
        if (load_year) begin
            year_reg <= year_next;
        end
    end

    assign whole_years = DAYS_W'(year_reg.year_off) * DAYS_PER_YEAR
                       + DAYS_W'(year_reg.leap_corr);

    always_comb begin
        days_next.ok   = year_reg.ok;
        days_next.tod  = year_reg.tod;
        days_next.days = (year_reg.after_epoch ? whole_years : '0)
                       + DAYS_W'(year_reg.day_of_year);
    end

    always_ff @(posedge aclk) begin
        if (load_days) begin
            days_reg <= days_next;
        end
    end

    assign days = days_reg;

endmodule

// File: rtl/core/ctes_sec_scale.sv
// Stage 3: days times 86400 plus time of day, forced to zero for a rejected item.
// Depends on ctes_pkg.
module ctes_sec_scale import ctes_pkg::*; (
    input  logic    aclk,
    input  logic    load,
    input  days_t   days,
    output result_t result
);

    result_t           result_reg;
    result_t           result_next;
    logic [SECS_W-1:0] day_secs;

    assign day_secs = SECS_W'(days.days) * SECS_W'(SECS_PER_DAY);

    always_comb begin
        result_next.ok   = days.ok;
        result_next.secs = days.ok ? (day_secs + SECS_W'(days.tod)) : '0;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule
